// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the sorted insert list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sil_pkg.sv -----
// Package with the codes and shared types of the sorted insert list.
package sil_pkg;

  // Operation codes carried by the kind field.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Per-cell load controls issued by the top level.
  typedef struct packed {
    logic load_new;  // take the incoming key and handle
    logic shift_in;  // take the entry of the left neighbor
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/sil_if.sv -----
// Handshake interfaces for the request and result channels.
interface sil_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] key;
  logic [31:0] handle;
  logic [5:0]  position;

  modport source (output valid, kind, key, handle, position, input ready);
  modport sink   (input valid, kind, key, handle, position, output ready);
endinterface

interface sil_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_key;
  logic [31:0] read_handle;
  logic [6:0]  entry_count;
  logic [1:0]  status;

  modport source (output valid, read_key, read_handle, entry_count, status, input ready);
  modport sink   (input valid, read_key, read_handle, entry_count, status, output ready);
endinterface

// ----- hw/rtl/sil_cell.sv -----
// One list slot: holds a key and handle and compares its key with a new one.
module sil_cell (
  input  logic                clk,
  input  sil_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic                descending,
  input  logic [31:0]         new_key,
  input  logic [31:0]         new_handle,
  input  logic [31:0]         prev_key,
  input  logic [31:0]         prev_handle,
  output logic [31:0]         key_q,
  output logic [31:0]         handle_q,
  output logic                out_of_order
);
  import sil_pkg::*;

  logic [31:0] key_r;
  logic [31:0] handle_r;
  logic [31:0] key_nxt;
  logic [31:0] handle_nxt;

  // An empty slot counts as out of order so that it never blocks the search.
  always_comb begin
    if (!occupied) begin
      out_of_order = 1'b1;
    end else if (descending) begin
      out_of_order = key_r < new_key;
    end else begin
      out_of_order = key_r > new_key;
    end
  end

  always_comb begin
    key_nxt    = key_r;
    handle_nxt = handle_r;
    if (ctrl.load_new) begin
      key_nxt    = new_key;
      handle_nxt = new_handle;
    end else if (ctrl.shift_in) begin
      key_nxt    = prev_key;
      handle_nxt = prev_handle;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
  end

  assign key_q    = key_r;
  assign handle_q = handle_r;

endmodule

// ----- hw/rtl/sorted_insert_list_unit.sv -----
// Top level of the sorted insert list: a row of key cells with a registered result.
//
//   channel   dir  handshake             payload
//   in_chan   in   valid / ready         kind, key, handle, position
//   out_chan  out  valid / ready         read_key, read_handle, entry_count, status
//   cfg       in   cfg_wr_en (no ready)  cfg_wr_data = descending
//
// The result of an accepted item is in the output register the cycle after it is
// accepted, and a new item can be accepted in every cycle while the output register
// is empty or being taken. That rate comes from the row of cells, where each cell
// compares its key with the new one at once and the whole row shifts in the same edge.
// Reset (rst_n low at a clock edge) empties the list, clears the order setting
// and the output valid; the key and handle cells are not cleared.
// in_chan.ready is high while the output register is empty or being taken.
module sorted_insert_list_unit #(
  parameter int LIST_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  sil_in_if.sink   in_chan,
  sil_out_if.source out_chan,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);
  import sil_pkg::*;

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  // Order setting and fill count of the list.
  logic             descending_r;
  logic [CNT_W-1:0] fill_count_r;
  logic [CNT_W-1:0] fill_count_nxt;

  // Output register.
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] read_key_r;
  logic [31:0] read_handle_r;
  logic [6:0]  entry_count_r;
  logic [1:0]  status_r;
  logic [31:0] read_key_nxt;
  logic [31:0] read_handle_nxt;
  logic [1:0]  status_nxt;

  logic in_acc;
  logic list_full;
  logic ins_go;

  // Row of cells and the signals between them.
  logic [LIST_DEPTH-1:0] ooo_vec;
  logic [LIST_DEPTH-1:0] suffix_all;
  logic [LIST_DEPTH-1:0] load_new_vec;
  logic [31:0]           key_vec    [LIST_DEPTH];
  logic [31:0]           handle_vec [LIST_DEPTH];

  // The input side is free whenever the result register can take a new value.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign list_full     = fill_count_r == CNT_W'(LIST_DEPTH);
  assign ins_go        = in_acc && (in_chan.kind == KIND_INSERT) && !list_full;

  // An insert walks from the end of the list toward the front past every entry
  // that is strictly out of order with the new key. In the row that means:
  // every cell from k to the end is out of order (empty cells count as such)
  // exactly when the entry in cell k moves one place right. The new entry lands
  // in the cell whose left neighbor stops the walk, or in cell zero.
  genvar k;
  generate
    for (k = 0; k < LIST_DEPTH; k++) begin : g_cell
      localparam logic [LIST_DEPTH-1:0] LOW_MASK =
        (LIST_DEPTH'(1) << k) - LIST_DEPTH'(1);

      cell_ctrl_t  ctrl;
      logic        occupied;
      logic [31:0] prev_key;
      logic [31:0] prev_handle;

      assign occupied      = fill_count_r > CNT_W'(k);
      assign suffix_all[k] = &(ooo_vec | LOW_MASK);

      if (k == 0) begin : g_head
        assign ctrl.load_new = ins_go && suffix_all[k];
        assign ctrl.shift_in = 1'b0;
        assign prev_key      = in_chan.key;
        assign prev_handle   = in_chan.handle;
      end else begin : g_body
        assign ctrl.load_new = ins_go && suffix_all[k] && !ooo_vec[k-1];
        assign ctrl.shift_in = ins_go && suffix_all[k-1];
        assign prev_key      = key_vec[k-1];
        assign prev_handle   = handle_vec[k-1];
      end

      assign load_new_vec[k] = ctrl.load_new;

      sil_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .occupied     (occupied),
        .descending   (descending_r),
        .new_key      (in_chan.key),
        .new_handle   (in_chan.handle),
        .prev_key     (prev_key),
        .prev_handle  (prev_handle),
        .key_q        (key_vec[k]),
        .handle_q     (handle_vec[k]),
        .out_of_order (ooo_vec[k])
      );
    end
  endgenerate

  // Result of the accepted item, worked out from the list as it stands before
  // the edge. A read selects its cell by position; only held entries count.
  always_comb begin
    fill_count_nxt  = fill_count_r;
    read_key_nxt    = '0;
    read_handle_nxt = '0;
    status_nxt      = STAT_OK;
    case (in_chan.kind)
      KIND_INSERT: begin
        if (list_full) begin
          status_nxt = STAT_FULL;
        end else begin
          fill_count_nxt = fill_count_r + CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (32'(in_chan.position) < 32'(fill_count_r)) begin
          for (int i = 0; i < LIST_DEPTH; i++) begin
            if (32'(in_chan.position) == i) begin
              read_key_nxt    = key_vec[i];
              read_handle_nxt = handle_vec[i];
            end
          end
        end else begin
          status_nxt = STAT_EMPTY;
        end
      end
      KIND_CLEAR: begin
        fill_count_nxt = '0;
      end
      default: begin
        fill_count_nxt = fill_count_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      descending_r <= 1'b0;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        descending_r <= cfg_wr_data;
      end
      if (in_acc) begin
        fill_count_r <= fill_count_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      read_key_r    <= read_key_nxt;
      read_handle_r <= read_handle_nxt;
      entry_count_r <= 7'(fill_count_nxt);
      status_r      <= status_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.read_key    = read_key_r;
  assign out_chan.read_handle = read_handle_r;
  assign out_chan.entry_count = entry_count_r;
  assign out_chan.status      = status_r;

  // The list never holds more entries than it has cells.
  `ASSERT_IMPL(a_fill_bound, 1'b1, fill_count_r <= CNT_W'(LIST_DEPTH),
               "fill count beyond list depth")
  // A successful insert lands in exactly one cell, and nothing loads otherwise.
  `ASSERT_IMPL(a_one_landing, ins_go, $onehot(load_new_vec),
               "insert did not land in exactly one cell")
  `ASSERT_IMPL(a_no_landing, !ins_go, load_new_vec == '0,
               "cell loaded without an insert")
  // An insert into a full list is reported and leaves the count alone.
  `ASSERT_NEXT(a_full_drop, in_acc && in_chan.kind == KIND_INSERT && list_full,
               status_r == STAT_FULL && $stable(fill_count_r),
               "dropped insert not reported or count changed")
  // A successful insert grows the list by one.
  `ASSERT_NEXT(a_insert_grow, ins_go, fill_count_r == $past(fill_count_r) + CNT_W'(1),
               "insert did not grow the list by one")

endmodule
